FILE: hdl/positional_list_store_defines.svh
// Assertion macros shared by the positional list store.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pls_pkg.sv
// Types and constants of the positional list store.
package pls_pkg;

    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;
    localparam int OP_W   = 2;
    localparam int TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

FILE: hdl/pls_ctrl.sv
// Controller state machine of the positional list store.
module pls_ctrl
    import pls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the word until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: hdl/pls_datapath.sv
// Entry store, length counter and result register of the positional list store.
module pls_datapath
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [OP_W-1:0]    in_op,
    input  logic [POS_W-1:0]   in_position,
    input  logic [VAL_W-1:0]   in_value,
    output logic               res_ok,
    output logic [VAL_W-1:0]   res_read_value,
    output logic [LEN_W-1:0]   res_length,
    output logic               res_empty,
    output logic [CW-1:0]      count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int EW    = (CW > POS_W) ? CW : POS_W;

    op_t                    op_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [DATA_WIDTH-1:0]  word_reg;
    logic [DATA_WIDTH-1:0]  entries_reg [CAPACITY];
    logic [DATA_WIDTH-1:0]  entries_next [CAPACITY];
    logic [CW-1:0]          count_reg, count_next;
    logic                   ok_reg, ok_next;
    logic [VAL_W-1:0]       rdata_reg;
    logic [DATA_WIDTH-1:0]  rd_next;
    logic [LEN_W-1:0]       len_reg;
    logic                   empty_reg;
    logic [EW-1:0]          pos_ext, cnt_ext;
    logic                   not_full, do_app, do_ins, do_rem;

    assign pos_ext  = EW'(pos_reg);
    assign cnt_ext  = EW'(count_reg);
    assign not_full = (count_reg < CW'(CAPACITY));

    always_comb
    begin
        ok_next    = 1'b0;
        rd_next    = '0;
        count_next = count_reg;
        do_app     = 1'b0;
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (not_full)
                begin
                    do_app     = 1'b1;
                    ok_next    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INSERT:
            begin
                if (not_full && (pos_ext <= cnt_ext))
                begin
                    do_ins     = 1'b1;
                    ok_next    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    do_rem     = 1'b1;
                    ok_next    = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ok_next = 1'b1;
                    rd_next = entries_reg[pos_ext[IDX_W-1:0]];
                end
            end
        endcase
    end

    // shift every later entry in parallel
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_app && (count_reg[IDX_W-1:0] == IDX_W'(i)))
                entries_next[i] = word_reg;
            if (do_ins)
            begin
                if (EW'(i) == pos_ext)
                    entries_next[i] = word_reg;
                else if (EW'(i) > pos_ext)
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
            end
            if (do_rem && (EW'(i) >= pos_ext) && (i < CAPACITY - 1))
                entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(in_op);
            pos_reg  <= in_position;
            word_reg <= DATA_WIDTH'(in_value);
        end
        if (cmd.exec)
        begin
            entries_reg <= entries_next;
            ok_reg      <= ok_next;
            rdata_reg   <= VAL_W'(rd_next);
            len_reg     <= LEN_W'(count_next);
            empty_reg   <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    assign res_ok         = ok_reg;
    assign res_read_value = rdata_reg;
    assign res_length     = len_reg;
    assign res_empty      = empty_reg;
    assign count          = count_reg;

endmodule

FILE: hdl/positional_list_store.sv
// Top level of the positional list store.
//
// Ordered list of up to CAPACITY words. Each input word on the s_ channel
// carries one operation in s_tuser (append, insert, remove, read) and a
// position and value in s_tdata. Each operation returns exactly one result
// word on the m_ channel: success flag, read word, new length, empty flag.
// Insert and remove move every later entry one place, all in parallel.
// The controller takes each input word in its load step and registers the
// result in its execute step; s_tready is low during the execute step, so
// a new input word is not taken until the last one has executed.
// Stall: a result waits in the output register while m_tready is low; the
// next input word is still taken, and its execute step holds until the
// output register is free.
// Reset: the list is emptied (length zero); stored words are undefined
// until written, but no entry past the length is ever read.
// Values keep their low DATA_WIDTH bits; read words are zero on failure.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // position[4:0], value[36:5], zero pad
    input  logic [OP_W-1:0]    s_tuser,  // op[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // ok[0], read_value[32:1], length[37:33],
                                         // empty_res[38], zero pad
);

`include "positional_list_store_defines.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    cmd_t              cmd;
    logic              res_ok;
    logic [VAL_W-1:0]  res_read_value;
    logic [LEN_W-1:0]  res_length;
    logic              res_empty;
    logic [CW-1:0]     count;

    pls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pls_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_op          (s_tuser),
        .in_position    (s_tdata[POS_W-1:0]),
        .in_value       (s_tdata[POS_W+VAL_W-1:POS_W]),
        .res_ok         (res_ok),
        .res_read_value (res_read_value),
        .res_length     (res_length),
        .res_empty      (res_empty),
        .count          (count)
    );

    assign m_tdata = {1'b0, res_empty, res_length, res_read_value, res_ok};

    `PLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken while an operation is still executing")

    `PLS_ASSERT_SAME(a_count_in_range, clk, rst_n, 1'b1, count <= CW'(CAPACITY),
        "list length exceeds capacity")

    `PLS_ASSERT_SAME(a_fail_reads_zero, clk, rst_n, m_tvalid && !m_tdata[0],
        m_tdata[32:1] == '0, "failed operation returned a nonzero read word")

endmodule
